FILE: hdl/rsdf_pkg.sv
// rsdf_pkg: shared constants, codes and types of the row select filter
// used by rsdf_eval and the top module, no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsdf_pkg;

  localparam int MAX_COLUMNS_DEF      = 16;
  localparam int MAX_CLAUSE_SLOTS_DEF = 16;
  localparam int OR_GROUPS_DEF        = 4;
  localparam int AND_TERMS_DEF        = 4;
  localparam int OUTPUT_ROWS_DEF      = 65536;

  localparam int CLAUSE_W = 44;
  localparam int WORD_W   = 32;
  localparam int GRP_W    = 3;

  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_LT = 3'd1,
    OP_LE = 3'd2,
    OP_GT = 3'd3,
    OP_GE = 3'd4,
    OP_NE = 3'd5
  } cmp_op_e;

  typedef enum logic [2:0] {
    REG_COLUMNS   = 3'd0,
    REG_CLAUSES   = 3'd1,
    REG_CONNECT   = 3'd2,
    REG_OUT_BASE  = 3'd3,
    REG_TABLE     = 3'd4
  } cfg_reg_e;

  localparam logic CMD_CLAUSE = 1'b0;
  localparam logic CMD_ROW    = 1'b1;

  typedef struct packed {
    logic clear;
    logic step;
    logic first;
    logic join_or;
  } rsdf_ev_ctrl_t;

  function automatic logic compare(input logic [2:0] op, input logic [WORD_W-1:0] a,
                                   input logic [WORD_W-1:0] b);
    logic r;
    r = 1'b0;
    case (op)
      OP_EQ:   r = (a == b);
      OP_LT:   r = (a < b);
      OP_LE:   r = (a <= b);
      OP_GT:   r = (a > b);
      OP_GE:   r = (a >= b);
      OP_NE:   r = (a != b);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rsdf_mem.sv
// rsdf_mem: synchronous memory, one write port and two registered read ports
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rsdf_mem #(
  parameter int W = 32,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [W-1:0]  wdata_i,
  input  wire logic          re_a_i,
  input  wire logic [AW-1:0] raddr_a_i,
  output logic      [W-1:0]  rdata_a_o,
  input  wire logic          re_b_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [W-1:0]  rdata_b_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rsdf_eval.sv
// rsdf_eval: compare unit and or-of-and group accumulator, one clause a step
// depends on rsdf_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsdf_eval #(
  parameter int OR_GROUPS = 4,
  parameter int AND_TERMS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rsdf_pkg::rsdf_ev_ctrl_t      ctrl_i,
  input  wire logic [2:0]                   op_i,
  input  wire logic [rsdf_pkg::WORD_W-1:0]  a_i,
  input  wire logic [rsdf_pkg::WORD_W-1:0]  b_i,
  output logic                              any_o
);
  import rsdf_pkg::*;

  logic [GRP_W-1:0]     g_q, g_d, t_q, t_d;
  logic [OR_GROUPS-1:0] open_q, open_d, hold_q, hold_d;
  logic                 q;

  assign q = compare(op_i, a_i, b_i);

  always_comb begin
    g_d = g_q;
    t_d = t_q;
    open_d = open_q;
    hold_d = hold_q;
    if (ctrl_i.clear) begin
      g_d = '0;
      t_d = '0;
      open_d = '0;
      hold_d = '0;
    end else if (ctrl_i.step) begin
      if (!ctrl_i.first && ctrl_i.join_or) begin
        if (g_q < GRP_W'(OR_GROUPS)) g_d = g_q + 1'b1;
        t_d = '0;
      end
      if (g_d < GRP_W'(OR_GROUPS) && t_d < GRP_W'(AND_TERMS)) begin
        for (int i = 0; i < OR_GROUPS; i++) begin
          if (g_d == GRP_W'(i)) begin
            if (t_d == '0) begin
              open_d[i] = 1'b1;
              hold_d[i] = q;
            end else begin
              hold_d[i] = hold_q[i] & q;
            end
          end
        end
        t_d = t_d + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q <= '0;
      t_q <= '0;
      open_q <= '0;
      hold_q <= '0;
    end else begin
      g_q <= g_d;
      t_q <= t_d;
      open_q <= open_d;
      hold_q <= hold_d;
    end
  end

  assign any_o = |(open_q & hold_q);

  a_grp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_q <= GRP_W'(OR_GROUPS)) else $error("group index beyond range");
  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    t_q <= GRP_W'(AND_TERMS)) else $error("term count beyond range");
  a_hold_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |=> (open_q == '0) && !any_o) else $error("clear left a group");

endmodule

`default_nettype wire

FILE: hdl/row_select_dnf_filter_top.sv
// row_select_dnf_filter_top: select filter over streamed table rows
// depends on rsdf_pkg, rsdf_mem, rsdf_eval
//
// s_axis carries one word per beat: tuser 0 loads a clause into the clause
// memory, tuser 1 delivers the next column word of the current row, which
// goes into the row buffer memory. cfg writes set row width, clause count,
// connectors, output base and table size; they are taken in any cycle.
// At a row's last word the clauses are evaluated one at a time (clause
// read, column read, compare), then a decide step follows. An accepted row
// gets its output address by reciprocal multiply, then remainder, and is
// then sent on m_axis one word at a time, each read first from the
// registered row buffer. Load and ordinary row words are accepted only
// while the sequencer is idle. m_axis has an output register: the next
// input is taken while the last word of a row waits, and a stall of the
// receiver holds the sequencer in its emit step. Reset clears the control
// registers and counters; datapath registers and memories start undefined.
`timescale 1ns / 1ps
`default_nettype none

module row_select_dnf_filter_top
  import rsdf_pkg::*;
#(
  parameter int MAX_COLUMNS      = MAX_COLUMNS_DEF,
  parameter int MAX_CLAUSE_SLOTS = MAX_CLAUSE_SLOTS_DEF,
  parameter int OR_GROUPS        = OR_GROUPS_DEF,
  parameter int AND_TERMS        = AND_TERMS_DEF,
  parameter int OUTPUT_ROWS      = OUTPUT_ROWS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // clause_slot, clause_kind, compare_op, left_column, right_column,
  // compare_value, row_word
  input  wire logic [79:0] s_axis_tdata,
  // cmd
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // out_row_address, out_column, out_word, zero fill
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SW = (MAX_CLAUSE_SLOTS > 1) ? $clog2(MAX_CLAUSE_SLOTS) : 1;
  localparam logic [33:0] RECIP = 34'((64'd1 << 33) / OUTPUT_ROWS);
  localparam logic [16:0] NROWS = 17'(OUTPUT_ROWS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CL   = 3'd1;
  localparam logic [2:0] ST_RB   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_END  = 3'd4;
  localparam logic [2:0] ST_ADQ  = 3'd5;
  localparam logic [2:0] ST_ADR  = 3'd6;
  localparam logic [2:0] ST_EMIT = 3'd7;

  logic [2:0]  state_q, state_d;
  logic        em_ld_q, em_ld_d;
  logic [4:0]  cols_cfg_q, count_cfg_q;
  logic [14:0] conn_q;
  logic [15:0] base_q, table_q;
  logic [3:0]  pos_q, pos_d;
  logic [15:0] seen_q, seen_d, acc_q, acc_d;
  logic        in_table_q, in_table_d;
  logic [4:0]  n_q, n_d;
  logic [3:0]  c_q, c_d;
  logic [16:0] quo_q, quo_d;
  logic [15:0] addr_q, addr_d;
  logic        ov_q, ov_d, olast_q, olast_d;
  logic [3:0]  ocol_q, ocol_d;
  logic [15:0] oaddr_q, oaddr_d;
  logic [31:0] oword_q, oword_d;

  logic [4:0]  cols, count;
  logic        accept, row_end;
  logic [3:0]  in_slot, in_left, in_right;
  logic [2:0]  in_op;
  logic        in_kind;
  logic [31:0] in_value, in_word;

  logic [CLAUSE_W-1:0] cl_rd;
  logic [31:0]         ra_rd, rb_rd, opa, opb;
  logic                cl_we, cl_re, rb_we, ra_re, rb_re;
  logic [CW-1:0]       ra_addr;
  rsdf_ev_ctrl_t       ev;
  logic                any;
  logic [15:0]         conn_ext;
  logic [16:0]         sum, rem0, rem1;
  logic [50:0]         prod;

  assign in_slot  = s_axis_tdata[3:0];
  assign in_kind  = s_axis_tdata[4];
  assign in_op    = s_axis_tdata[7:5];
  assign in_left  = s_axis_tdata[11:8];
  assign in_right = s_axis_tdata[15:12];
  assign in_value = s_axis_tdata[47:16];
  assign in_word  = s_axis_tdata[79:48];

  always_comb begin
    cols = cols_cfg_q;
    if (cols == '0) cols = 5'd1;
    if (32'(cols) > MAX_COLUMNS) cols = 5'(MAX_COLUMNS);
    if (cols > 5'd16) cols = 5'd16;
    count = (32'(count_cfg_q) > MAX_CLAUSE_SLOTS) ? 5'(MAX_CLAUSE_SLOTS) : count_cfg_q;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign row_end = ({1'b0, pos_q} + 5'd1 >= cols);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_cfg_q <= 5'd1;
      count_cfg_q <= '0;
      conn_q <= '0;
      base_q <= '0;
      table_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_COLUMNS:  cols_cfg_q <= cfg_data_i[4:0];
        REG_CLAUSES:  count_cfg_q <= cfg_data_i[4:0];
        REG_CONNECT:  conn_q <= cfg_data_i[14:0];
        REG_OUT_BASE: base_q <= cfg_data_i;
        REG_TABLE:    table_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign cl_we = accept && (s_axis_tuser == CMD_CLAUSE) && (32'(in_slot) < MAX_CLAUSE_SLOTS);
  assign cl_re = (state_q == ST_CL);
  assign rb_we = accept && (s_axis_tuser == CMD_ROW) && (32'(pos_q) < MAX_COLUMNS);
  assign ra_re = (state_q == ST_RB) || ((state_q == ST_EMIT) && !em_ld_q);
  assign rb_re = (state_q == ST_RB);
  assign ra_addr = (state_q == ST_EMIT) ? CW'(c_q) : CW'(cl_rd[7:4]);

  rsdf_mem #(.W(CLAUSE_W), .D(MAX_CLAUSE_SLOTS)) u_clause_mem (
    .clk_i     (clk_i),
    .we_i      (cl_we),
    .waddr_i   (SW'(in_slot)),
    .wdata_i   ({in_value, in_right, in_left, in_op, in_kind}),
    .re_a_i    (cl_re),
    .raddr_a_i (SW'(n_q)),
    .rdata_a_o (cl_rd),
    .re_b_i    (1'b0),
    .raddr_b_i ('0),
    .rdata_b_o ()
  );

  rsdf_mem #(.W(WORD_W), .D(MAX_COLUMNS)) u_row_mem (
    .clk_i     (clk_i),
    .we_i      (rb_we),
    .waddr_i   (CW'(pos_q)),
    .wdata_i   (in_word),
    .re_a_i    (ra_re),
    .raddr_a_i (ra_addr),
    .rdata_a_o (ra_rd),
    .re_b_i    (rb_re),
    .raddr_b_i (CW'(cl_rd[11:8])),
    .rdata_b_o (rb_rd)
  );

  assign opa = ({1'b0, cl_rd[7:4]} < cols) ? ra_rd : '0;
  assign opb = cl_rd[0] ? (({1'b0, cl_rd[11:8]} < cols) ? rb_rd : '0) : cl_rd[43:12];
  assign conn_ext = {1'b0, conn_q};

  always_comb begin
    ev.clear   = accept && (s_axis_tuser == CMD_ROW) && row_end;
    ev.step    = (state_q == ST_CMP);
    ev.first   = (n_q == '0);
    ev.join_or = conn_ext[n_q[3:0] - 4'd1];
  end

  rsdf_eval #(.OR_GROUPS(OR_GROUPS), .AND_TERMS(AND_TERMS)) u_eval (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ev),
    .op_i   (cl_rd[3:1]),
    .a_i    (opa),
    .b_i    (opb),
    .any_o  (any)
  );

  assign sum  = {1'b0, base_q} + {1'b0, acc_q};
  assign prod = 51'(sum) * 51'(RECIP);
  assign rem0 = sum - 17'(quo_q * NROWS);
  assign rem1 = (rem0 >= NROWS) ? rem0 - NROWS : rem0;

  always_comb begin
    state_d = state_q;
    em_ld_d = em_ld_q;
    pos_d = pos_q;
    seen_d = seen_q;
    acc_d = acc_q;
    in_table_d = in_table_q;
    n_d = n_q;
    c_d = c_q;
    quo_d = quo_q;
    addr_d = addr_q;
    ov_d = ov_q && !m_axis_tready;
    olast_d = olast_q;
    ocol_d = ocol_q;
    oaddr_d = oaddr_q;
    oword_d = oword_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser == CMD_ROW) begin
          if (!row_end) begin
            pos_d = pos_q + 4'd1;
          end else begin
            pos_d = '0;
            in_table_d = (seen_q < table_q);
            if (seen_q != 16'hFFFF) seen_d = seen_q + 16'd1;
            n_d = '0;
            state_d = (count == '0) ? ST_END : ST_CL;
          end
        end
      end
      ST_CL:  state_d = ST_RB;
      ST_RB:  state_d = ST_CMP;
      ST_CMP: begin
        n_d = n_q + 5'd1;
        state_d = (n_q + 5'd1 == count) ? ST_END : ST_CL;
      end
      ST_END: state_d = (in_table_q && any) ? ST_ADQ : ST_IDLE;
      ST_ADQ: begin
        quo_d = prod[49:33];
        state_d = ST_ADR;
      end
      ST_ADR: begin
        addr_d = rem1[15:0];
        c_d = '0;
        em_ld_d = 1'b0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!em_ld_q) begin
          em_ld_d = 1'b1;
        end else if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1;
          oaddr_d = addr_q;
          ocol_d = c_q;
          oword_d = ra_rd;
          olast_d = ({1'b0, c_q} + 5'd1 == cols);
          em_ld_d = 1'b0;
          if ({1'b0, c_q} + 5'd1 == cols) begin
            acc_d = acc_q + 16'd1;
            state_d = ST_IDLE;
          end else begin
            c_d = c_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      em_ld_q <= 1'b0;
      pos_q <= '0;
      seen_q <= '0;
      acc_q <= '0;
      in_table_q <= 1'b0;
      n_q <= '0;
      c_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      em_ld_q <= em_ld_d;
      pos_q <= pos_d;
      seen_q <= seen_d;
      acc_q <= acc_d;
      in_table_q <= in_table_d;
      n_q <= n_d;
      c_q <= c_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    addr_q <= addr_d;
    olast_q <= olast_d;
    ocol_q <= ocol_d;
    oaddr_q <= oaddr_d;
    oword_q <= oword_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast = olast_q;
  assign m_axis_tdata = {4'd0, oword_q, ocol_q, oaddr_q};

  a_cmp_in_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> n_q < count) else $error("clause index past count");
  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> {1'b0, c_q} < cols) else $error("emit column past row");
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && em_ld_q && (!ov_q || m_axis_tready)
     && {1'b0, c_q} + 5'd1 == cols) |=> state_q == ST_IDLE && ov_q && olast_q)
    else $error("row end not closed");
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> {1'b0, addr_q} < NROWS) else $error("address not reduced");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for row_select_dnf_filter_top, directed table then random
// phases under varying back-pressure; depends on rsdf_pkg and the filter rtl
`timescale 1ns / 1ps

module tb_top;
  import rsdf_pkg::*;

  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 5000;

  typedef struct packed {
    logic        kind;
    logic [2:0]  op;
    logic [3:0]  left;
    logic [3:0]  right;
    logic [31:0] value;
  } clause_t;

  typedef struct {
    logic [15:0] addr;
    logic [3:0]  col;
    logic [31:0] data;
    logic        last;
  } out_word_t;

  typedef enum {STEP_CFG, STEP_WORD} step_kind_e;

  typedef struct {
    step_kind_e  kind;
    cfg_reg_e    idx;
    logic [15:0] cfg;
    logic        cmd;
    logic [79:0] data;
    int          n_out;
  } step_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  row_select_dnf_filter_top dut (.*);

  // predictor state
  logic [4:0]  columns_q;
  logic [4:0]  clauses_q;
  logic [14:0] connect_q;
  logic [15:0] base_q;
  logic [15:0] table_q;
  clause_t     clause_mem [16];
  logic [31:0] row_mem [16];
  int unsigned col_pos, rows_seen, rows_taken;
  out_word_t   expected_q[$];

  int errors = 0;
  int idle_mode = 0;
  int hold_req = 0;
  int n_words_in = 0, n_words_out = 0, n_rows_out = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int eff_cols();
    int c;
    c = columns_q;
    if (c == 0) c = 1;
    if (c > 16) c = 16;
    return c;
  endfunction

  function automatic logic [31:0] col_val(logic [3:0] idx, int cols);
    return (idx >= cols) ? 32'd0 : row_mem[idx];
  endfunction

  function automatic logic clause_holds(clause_t cl, int cols);
    logic [31:0] a, b;
    a = col_val(cl.left, cols);
    b = cl.kind ? col_val(cl.right, cols) : cl.value;
    case (cl.op)
      OP_EQ:   return a == b;
      OP_LT:   return a < b;
      OP_LE:   return a <= b;
      OP_GT:   return a > b;
      OP_GE:   return a >= b;
      OP_NE:   return a != b;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic row_passes(int cols);
    logic opened [4];
    logic holds [4];
    int g, t, cnt;
    logic q, any;
    g = 0; t = 0; any = 1'b0;
    cnt = (clauses_q > 16) ? 16 : clauses_q;
    for (int i = 0; i < 4; i++) begin
      opened[i] = 1'b0;
      holds[i] = 1'b0;
    end
    for (int n = 0; n < cnt; n++) begin
      q = clause_holds(clause_mem[n], cols);
      if (n > 0 && connect_q[n-1]) begin
        if (g < 4) g++;
        t = 0;
      end
      if (g < 4 && t < 4) begin
        if (t == 0) begin
          opened[g] = 1'b1;
          holds[g] = q;
        end else begin
          holds[g] = holds[g] && q;
        end
        t++;
      end
    end
    for (int i = 0; i < 4; i++) if (opened[i] && holds[i]) any = 1'b1;
    return any;
  endfunction

  // returns the number of words the accepted input word causes
  function automatic int filter_word(logic cmd, logic [79:0] d);
    int cols, k;
    out_word_t w;
    k = 0;
    if (cmd == CMD_CLAUSE) begin
      clause_mem[d[3:0]] = '{d[4], d[7:5], d[11:8], d[15:12], d[47:16]};
      return 0;
    end
    cols = eff_cols();
    row_mem[col_pos] = d[79:48];
    if (col_pos + 1 < cols) begin
      col_pos++;
      return 0;
    end
    col_pos = 0;
    if (rows_seen < table_q && row_passes(cols)) begin
      for (int c = 0; c < cols; c++) begin
        w.addr = base_q + rows_taken[15:0];
        w.col = c[3:0];
        w.data = row_mem[c];
        w.last = (c + 1 == cols);
        expected_q.push_back(w);
        k++;
      end
      rows_taken = (rows_taken + 1) & 16'hFFFF;
    end
    if (rows_seen < 16'hFFFF) rows_seen++;
    return k;
  endfunction

  function automatic logic [79:0] clause_bits(int slot, logic kind, logic [2:0] op,
                                              int l, int r, logic [31:0] v);
    return {32'd0, v, r[3:0], l[3:0], op, kind, slot[3:0]};
  endfunction

  function automatic step_t cl(int slot, logic kind, logic [2:0] op, int l, int r,
                               logic [31:0] v);
    return '{STEP_WORD, REG_COLUMNS, 16'd0, CMD_CLAUSE, clause_bits(slot, kind, op, l, r, v), -1};
  endfunction

  function automatic step_t rw(logic [31:0] w, int n);
    return '{STEP_WORD, REG_COLUMNS, 16'd0, CMD_ROW, {w, 48'd0}, n};
  endfunction

  function automatic step_t cf(cfg_reg_e idx, logic [15:0] v);
    return '{STEP_CFG, idx, v, CMD_ROW, 80'd0, -1};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic wait_idle();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_COLUMNS:  columns_q = v[4:0];
      REG_CLAUSES:  clauses_q = v[4:0];
      REG_CONNECT:  connect_q = v[14:0];
      REG_OUT_BASE: base_q = v;
      REG_TABLE:    table_q = v;
      default:      ;
    endcase
  endtask

  task automatic send_word(logic cmd, logic [79:0] d, output int n);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 46) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 6)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    n = filter_word(cmd, d);
    n_words_in++;
  endtask

  task automatic run_step(step_t s);
    int n;
    if (s.kind == STEP_CFG) begin
      s_axis_tvalid <= 1'b0;
      write_reg(s.idx, s.cfg);
    end else begin
      send_word(s.cmd, s.data, n);
      if (s.n_out >= 0 && n != s.n_out) begin
        $display("%0t: row word count exp %0d act %0d", $time, s.n_out, n);
        errors++;
      end
    end
  endtask

  task automatic random_phase(int mode, logic [15:0] cols, logic [15:0] cnt,
                              logic [15:0] conn, logic [15:0] base, logic [15:0] tbl);
    int words;
    logic [79:0] d;
    int n;
    idle_mode = mode;
    s_axis_tvalid <= 1'b0;
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_CLAUSES, cnt);
    write_reg(REG_CONNECT, conn);
    write_reg(REG_OUT_BASE, base);
    write_reg(REG_TABLE, tbl);
    // long receiver hold-off while words keep coming
    if (mode == 1) hold_req = 300;
    words = 0;
    while (words < 14) begin
      if ($urandom_range(0, 6) == 0) begin
        d = clause_bits($urandom_range(0, 15), 1'($urandom_range(0, 1)),
                        3'($urandom_range(0, 7)), $urandom_range(0, 15),
                        $urandom_range(0, 15), pick_word());
        send_word(CMD_CLAUSE, d, n);
      end else begin
        send_word(CMD_ROW, {pick_word(), 48'd0}, n);
      end
      words++;
    end
    // finish the row in progress so the next phase starts aligned
    while (col_pos != 0) send_word(CMD_ROW, {pick_word(), 48'd0}, n);
  endtask

  initial begin
    step_t dir_steps [$];
    int n;
    columns_q = 5'd1; clauses_q = '0; connect_q = '0; base_q = '0; table_q = '0;
    col_pos = 0; rows_seen = 0; rows_taken = 0;
    dir_steps = '{
      cf(REG_COLUMNS, 16'd2), cf(REG_TABLE, 16'hFFFF), cf(REG_CLAUSES, 16'd1),
      cl(0, 1'b0, OP_EQ, 0, 0, 32'd5),
      rw(32'd5, 0), rw(32'hFFFF_FFFF, 2),
      rw(32'd6, 0), rw(32'd0, 0),
      cl(1, 1'b1, OP_LT, 0, 1, 32'd0),
      cl(2, 1'b0, 3'd6, 0, 0, 32'd0),
      cl(3, 1'b1, OP_GT, 1, 15, 32'd0),
      cf(REG_CONNECT, 16'h7FFF), cf(REG_CLAUSES, 16'd4),
      rw(32'd0, 0), rw(32'd0, 0),
      rw(32'd1, 0), rw(32'd2, 2),
      cl(4, 1'b0, OP_GE, 0, 0, 32'hFFFF_FFFF),
      cl(5, 1'b0, OP_NE, 1, 0, 32'd0),
      cl(6, 1'b0, OP_LE, 0, 0, 32'hFFFF_FFFF),
      cf(REG_CONNECT, 16'd0), cf(REG_CLAUSES, 16'd7),
      rw(32'd5, 0), rw(32'd0, -1),
      cf(REG_OUT_BASE, 16'hFFFF), cf(REG_CONNECT, 16'd1), cf(REG_CLAUSES, 16'd2),
      rw(32'd5, 0), rw(32'd9, -1),
      cf(REG_COLUMNS, 16'd0),
      rw(32'd5, 1),
      cf(REG_COLUMNS, 16'd3),
      rw(32'd5, 0), rw(32'd5, 0),
      cf(REG_COLUMNS, 16'd1),
      rw(32'd7, 1),
      cf(REG_TABLE, 16'd0),
      rw(32'd5, 0)
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_steps[i]) run_step(dir_steps[i]);

    // fill every clause slot before larger clause counts are used
    s_axis_tvalid <= 1'b0;
    write_reg(REG_TABLE, 16'hFFFF);
    for (int s = 0; s < 16; s++)
      send_word(CMD_CLAUSE, clause_bits(s, 1'($urandom_range(0, 1)),
                3'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 15),
                pick_word()), n);

    random_phase(0, 16'd31, 16'd31, 16'($urandom_range(0, 32767)), 16'($urandom),
                 16'hFFFF);
    random_phase(1, 16'($urandom_range(1, 5)), 16'd16, 16'h7FFF, 16'($urandom),
                 16'hFFFF);
    random_phase(2, 16'($urandom_range(1, 5)), 16'($urandom_range(1, 16)),
                 16'($urandom_range(0, 32767)), 16'hFFFF, 16'hFFFF);
    random_phase(3, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 16)),
                 16'($urandom_range(0, 32767)), 16'($urandom), 16'(rows_seen + 3));
    random_phase(0, 16'd16, 16'($urandom_range(1, 16)), 16'($urandom_range(0, 32767)),
                 16'd0, 16'hFFFF);

    s_axis_tvalid <= 1'b0;
    wait_idle();
    $display("run covered %0d input words and %0d output words in %0d rows",
             n_words_in, n_words_out, n_rows_out);
    $display("all operations, clamped settings, dropped rows and address wrap exercised");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // receiver side: random stalls plus one long hold-off
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    out_word_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      n_words_out++;
      if (m_axis_tlast) n_rows_out++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word act %h last %b", $time, m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[15:0] != e.addr || m_axis_tdata[19:16] != e.col ||
            m_axis_tdata[51:20] != e.data || m_axis_tlast != e.last) begin
          $display("%0t: mismatch exp addr %h col %0d word %h last %b", $time,
                   e.addr, e.col, e.data, e.last);
          $display("%0t:          act addr %h col %0d word %h last %b", $time,
                   m_axis_tdata[15:0], m_axis_tdata[19:16], m_axis_tdata[51:20],
                   m_axis_tlast);
          errors++;
        end
      end
    end
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 46);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 6);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
